/* rtl/fas_pkg.sv */
// Shared types for the frame animation sequencer: payload words, configuration
// view, and the command/status words between controller and datapath.
// No dependencies.
`default_nettype none

package fas_pkg;

    localparam int APB_AW = 4;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] elapsed;
        logic [5:0]  entry_index;
        logic [15:0] entry_duration;
        logic        entry_pausable;
    } in_word_t;

    typedef struct packed {
        logic [5:0] frame_now;
        logic       is_paused;
        logic       is_finished;
        logic       success;
    } out_word_t;

    typedef struct packed {
        logic [6:0]  frame_count;
        logic        loop_enable;
        logic [15:0] default_duration;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_TICK_ADD,
        OP_SET_PEND,
        OP_FP_INIT,
        OP_RES_CLR,
        OP_FAIL,
        OP_FIN_SET,
        OP_RST_POS,
        OP_TBL_WR,
        OP_RES_CLAMP,
        OP_FIN_TIME,
        OP_SUM_INIT,
        OP_SUM_STEP,
        OP_MOD_INIT,
        OP_MOD_STEP,
        OP_MOD_FIN,
        OP_WALK,
        OP_FP_EVAL,
        OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] act;
        logic       paused;
        logic       loop_en;
        logic       sum_done;
        logic       mod_need;
        logic       mod_zero;
        logic       walk_more;
        logic       fp_more;
        logic       out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/frame_animation_sequencer_unit.sv */
// Frame animation sequencer, top level. Instantiates fas_cfg, fas_table,
// fas_dp and fas_ctrl; uses fas_pkg.
//
// Input channel s_valid/s_ready/s_data carries one command word (tick,
// pause request, force pause, resume, finish, reset, table write). Each
// word yields exactly one result word on m_valid/m_ready/m_data with the
// frame index, pause and finish flags and a success bit.
// Commands are processed one at a time. Resume, and finish without looping,
// end with the same frame advance as a tick. A tick on a looped animation
// sweeps the frame table once for the loop length, runs a bit-serial remainder
// when needed, then walks frames on the single table read port; force pause
// searches frame by frame on that port. A non-looped tick only walks frames.
// A finished result sits in the output register; the next word is accepted
// meanwhile, and the controller holds at result load until m_ready frees it.
// Reset (aresetn low, synchronous) returns to frame 0, clears pause state,
// marks all table entries as default and restores frame_count 1, looping
// on, default_duration 100. No clearing pass is needed.
// Config via APB at 0x0/0x4/0x8; write only while no command is in flight.
`default_nettype none

module frame_animation_sequencer_unit #(
    parameter int MAX_FRAMES = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire fas_pkg::in_word_t          s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output fas_pkg::out_word_t              m_data,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [fas_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);
    import fas_pkg::*;

    localparam int NMAX = (MAX_FRAMES < 127) ? MAX_FRAMES : 127;
    localparam int FIW  = (NMAX > 1) ? $clog2(NMAX) : 1;

    cfg_t           cfg;
    dp_cmd_t        cmd;
    dp_stat_t       stat;
    logic           tbl_wr_en;
    logic [5:0]     tbl_wr_addr;
    logic [15:0]    tbl_wr_dur;
    logic           tbl_wr_paus;
    logic [FIW-1:0] tbl_rd_addr;
    logic [15:0]    tbl_rd_dur;
    logic           tbl_rd_paus;

    fas_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fas_table #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_dur  (tbl_wr_dur),
        .wr_paus (tbl_wr_paus),
        .rd_addr (tbl_rd_addr),
        .rd_dur  (tbl_rd_dur),
        .rd_paus (tbl_rd_paus)
    );

    fas_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd         (cmd),
        .stat        (stat),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .tbl_wr_en   (tbl_wr_en),
        .tbl_wr_addr (tbl_wr_addr),
        .tbl_wr_dur  (tbl_wr_dur),
        .tbl_wr_paus (tbl_wr_paus),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_dur  (tbl_rd_dur),
        .tbl_rd_paus (tbl_rd_paus)
    );

    fas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

endmodule

`default_nettype wire

/* rtl/fas_cfg.sv */
// APB-style configuration registers: frame count, loop enable, default duration.
// Depends on fas_pkg.
`default_nettype none

module fas_cfg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [fas_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output fas_pkg::cfg_t                   cfg
);
    import fas_pkg::*;

    localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] REG_LOOP_ENABLE = 2'd1;
    localparam logic [1:0] REG_DEFAULT_DUR = 2'd2;

    logic [6:0]  frame_count_reg;
    logic        loop_enable_reg;
    logic [15:0] default_dur_reg;
    logic [1:0]  reg_sel;
    logic        wr_stb;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_stb  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= 7'd1;
            loop_enable_reg <= 1'b1;
            default_dur_reg <= 16'd100;
        end else if (wr_stb) begin
            case (reg_sel)
                REG_FRAME_COUNT: frame_count_reg <= pwdata[6:0];
                REG_LOOP_ENABLE: loop_enable_reg <= pwdata[0];
                REG_DEFAULT_DUR: default_dur_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FRAME_COUNT: prdata = 32'(frame_count_reg);
            REG_LOOP_ENABLE: prdata = 32'(loop_enable_reg);
            REG_DEFAULT_DUR: prdata = 32'(default_dur_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.frame_count      = frame_count_reg;
    assign cfg.loop_enable      = loop_enable_reg;
    assign cfg.default_duration = default_dur_reg;

endmodule

`default_nettype wire

/* rtl/fas_table.sv */
// Per-frame table memory: 16-bit duration override and pausable flag per entry,
// with valid bits so unwritten entries read as zero. Registered read.
`default_nettype none

module fas_table #(
    parameter  int MAX_FRAMES = 64,
    localparam int NMAX = (MAX_FRAMES < 127) ? MAX_FRAMES : 127,
    localparam int FIW  = (NMAX > 1) ? $clog2(NMAX) : 1
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           wr_en,
    input  wire logic [5:0]     wr_addr,
    input  wire logic [15:0]    wr_dur,
    input  wire logic           wr_paus,
    input  wire logic [FIW-1:0] rd_addr,
    output logic      [15:0]    rd_dur,
    output logic                rd_paus
);
    import fas_pkg::*;

    localparam int TD  = (MAX_FRAMES < 64) ? MAX_FRAMES : 64;
    localparam int TIW = (TD > 1) ? $clog2(TD) : 1;

    logic [16:0]    mem [TD];
    logic [TD-1:0]  vld_reg;
    logic [16:0]    rd_word_reg;
    logic           rd_vld_reg;
    logic           wr_ok;
    logic           rd_ok;
    logic [TIW-1:0] wi;
    logic [TIW-1:0] ri;

    assign wr_ok = wr_en && (int'(wr_addr) < TD);
    assign rd_ok = int'(rd_addr) < TD;
    assign wi    = wr_addr[TIW-1:0];
    assign ri    = rd_addr[TIW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wi] <= {wr_paus, wr_dur};
        end
        rd_word_reg <= mem[ri];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_ok) begin
                vld_reg[wi] <= 1'b1;
            end
            rd_vld_reg <= rd_ok && vld_reg[ri];
        end
    end

    assign rd_dur  = rd_vld_reg ? rd_word_reg[15:0] : 16'd0;
    assign rd_paus = rd_vld_reg && rd_word_reg[16];

endmodule

`default_nettype wire

/* rtl/fas_dp.sv */
// Datapath: frame position, time accumulator, pause flags, loop-sum and
// remainder unit, output register. Driven by fas_ctrl commands; uses fas_pkg.
`default_nettype none

module fas_dp #(
    parameter  int MAX_FRAMES = 64,
    localparam int NMAX = (MAX_FRAMES < 127) ? MAX_FRAMES : 127,
    localparam int FIW  = (NMAX > 1) ? $clog2(NMAX) : 1
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire fas_pkg::cfg_t  cfg,
    input  wire fas_pkg::dp_cmd_t cmd,
    output fas_pkg::dp_stat_t   stat,
    input  wire fas_pkg::in_word_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output fas_pkg::out_word_t  m_data,
    output logic                tbl_wr_en,
    output logic [5:0]          tbl_wr_addr,
    output logic [15:0]         tbl_wr_dur,
    output logic                tbl_wr_paus,
    output logic [FIW-1:0]      tbl_rd_addr,
    input  wire logic [15:0]    tbl_rd_dur,
    input  wire logic           tbl_rd_paus
);
    import fas_pkg::*;

    localparam int          NW        = $clog2(NMAX + 1);
    localparam int          SW        = 16 + FIW;
    localparam logic [31:0] DUR_MAX   = 32'd65535;
    localparam logic [5:0]  MOD_STEPS = 6'd32;

    in_word_t        item_reg, item_next;
    logic [FIW-1:0]  fi_reg, fi_next;
    logic [31:0]     time_reg, time_next;
    logic            paused_reg, paused_next;
    logic            pend_reg, pend_next;
    logic            ok_reg, ok_next;
    logic [FIW-1:0]  start_reg, start_next;
    logic [SW-1:0]   sum_reg, sum_next;
    logic            stop_reg, stop_next;
    logic [NW-1:0]   sum_cnt_reg, sum_cnt_next;
    logic            live_reg, live_next;
    logic [SW-1:0]   rem_reg, rem_next;
    logic [31:0]     dvd_reg, dvd_next;
    logic [5:0]      mod_cnt_reg, mod_cnt_next;
    logic            m_valid_reg, m_valid_next;
    out_word_t       m_data_reg, m_data_next;

    logic [NW-1:0]   n;
    logic [NW-1:0]   n_m1;
    logic [NW-1:0]   fi_ext;
    logic [NW-1:0]   nx;
    logic [FIW-1:0]  fi_inc;
    logic [15:0]     def_eff;
    logic [15:0]     dur;
    logic [31:0]     dur32;
    logic            at_last;
    logic            t_ge_d;
    logic [31:0]     t_sub;
    logic            walk_more;
    logic            fp_more;
    logic            moved;
    logic [32:0]     t_add;
    logic [SW:0]     rem_sh;
    logic [SW:0]     sum_ext;
    logic            rem_ge;

    // effective frame count, clamped to 1..NMAX
    always_comb begin
        if (cfg.frame_count == '0) begin
            n = NW'(1);
        end else if (int'(cfg.frame_count) > NMAX) begin
            n = NW'(NMAX);
        end else begin
            n = NW'(cfg.frame_count);
        end
    end

    assign n_m1    = n - NW'(1);
    assign fi_ext  = NW'(fi_reg);
    assign nx      = fi_ext + NW'(1);
    assign fi_inc  = (nx == n) ? '0 : FIW'(nx);
    assign def_eff = (cfg.default_duration == '0) ? 16'd1 : cfg.default_duration;
    assign dur     = (tbl_rd_dur != '0) ? tbl_rd_dur : def_eff;
    assign dur32   = 32'(dur);
    assign at_last = !cfg.loop_enable && (fi_ext == n_m1);
    assign t_ge_d  = time_reg >= dur32;
    assign t_sub   = time_reg - dur32;
    assign moved   = fi_reg != start_reg;
    assign t_add   = 33'(time_reg) + 33'(item_reg.elapsed);
    assign rem_sh  = {rem_reg, dvd_reg[31]};
    assign sum_ext = {1'b0, sum_reg};
    assign rem_ge  = rem_sh >= sum_ext;

    // catch-up keeps going only while what is left covers the frame just left
    assign walk_more = !(pend_reg && tbl_rd_paus) && !at_last && t_ge_d && (t_sub >= dur32);
    assign fp_more   = !tbl_rd_paus && !at_last && (fi_inc != start_reg);

    always_comb begin
        item_next    = item_reg;
        fi_next      = (fi_ext >= n) ? '0 : fi_reg;   // frame count shrunk
        time_next    = time_reg;
        paused_next  = paused_reg;
        pend_next    = pend_reg;
        ok_next      = ok_reg;
        start_next   = start_reg;
        sum_next     = sum_reg;
        stop_next    = stop_reg;
        sum_cnt_next = sum_cnt_reg;
        live_next    = 1'b0;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        mod_cnt_next = mod_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        tbl_wr_en    = 1'b0;
        tbl_rd_addr  = fi_reg;

        case (cmd.op)
            OP_LOAD: begin
                item_next = s_data;
                ok_next   = 1'b1;
            end
            OP_TICK_ADD: begin
                time_next = t_add[32] ? '1 : t_add[31:0];
            end
            OP_SET_PEND: begin
                pend_next = 1'b1;
            end
            OP_FP_INIT: begin
                pend_next  = 1'b1;
                start_next = fi_reg;
            end
            OP_RES_CLR: begin
                pend_next   = 1'b0;
                paused_next = 1'b0;
            end
            OP_FAIL: begin
                ok_next = 1'b0;
            end
            OP_FIN_SET: begin
                fi_next = FIW'(n_m1);
            end
            OP_RST_POS: begin
                fi_next     = '0;
                time_next   = '0;
                paused_next = 1'b0;
                pend_next   = 1'b0;
            end
            OP_TBL_WR: begin
                tbl_wr_en = 1'b1;
            end
            OP_RES_CLAMP: begin
                if (time_reg > dur32) begin
                    time_next = dur32;
                end
            end
            OP_FIN_TIME: begin
                time_next = dur32;
            end
            OP_SUM_INIT: begin
                sum_next     = '0;
                stop_next    = 1'b0;
                sum_cnt_next = '0;
            end
            OP_SUM_STEP: begin
                // reads stream one per cycle; the table read is registered, so data lags the address
                if (sum_cnt_reg < n) begin
                    tbl_rd_addr  = FIW'(sum_cnt_reg);
                    sum_cnt_next = sum_cnt_reg + NW'(1);
                    live_next    = 1'b1;
                end
                if (live_reg) begin
                    sum_next  = sum_reg + SW'(dur);
                    stop_next = stop_reg || (pend_reg && tbl_rd_paus);
                end
            end
            OP_MOD_INIT: begin
                dvd_next     = time_reg - DUR_MAX;
                rem_next     = '0;
                mod_cnt_next = MOD_STEPS;
            end
            OP_MOD_STEP: begin
                rem_next     = rem_ge ? SW'(rem_sh - sum_ext) : SW'(rem_sh);
                dvd_next     = {dvd_reg[30:0], 1'b0};
                mod_cnt_next = mod_cnt_reg - 6'd1;
            end
            OP_MOD_FIN: begin
                time_next = 32'(rem_reg) + DUR_MAX;
            end
            OP_WALK: begin
                if (pend_reg && tbl_rd_paus) begin
                    paused_next = 1'b1;
                end else if (!at_last && t_ge_d) begin
                    fi_next   = fi_inc;
                    time_next = t_sub;
                end
            end
            OP_FP_EVAL: begin
                if (tbl_rd_paus) begin
                    paused_next = 1'b1;
                    if (moved) begin
                        time_next = '0;
                    end
                end else if (at_last) begin
                    time_next = dur32;
                end else if (fi_inc == start_reg) begin
                    // wrapped all the way round: put the frame back
                    fi_next = start_reg;
                    ok_next = 1'b0;
                end else begin
                    fi_next = fi_inc;
                end
            end
            OP_OUT_LOAD: begin
                m_valid_next            = 1'b1;
                m_data_next.frame_now   = 6'(fi_reg);
                m_data_next.is_paused   = paused_reg;
                m_data_next.is_finished = at_last && t_ge_d;
                m_data_next.success     = ok_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fi_reg      <= '0;
            time_reg    <= '0;
            paused_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            live_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fi_reg      <= fi_next;
            time_reg    <= time_next;
            paused_reg  <= paused_next;
            pend_reg    <= pend_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        ok_reg      <= ok_next;
        start_reg   <= start_next;
        sum_reg     <= sum_next;
        stop_reg    <= stop_next;
        sum_cnt_reg <= sum_cnt_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        mod_cnt_reg <= mod_cnt_next;
        m_data_reg  <= m_data_next;
    end

    assign tbl_wr_addr = item_reg.entry_index;
    assign tbl_wr_dur  = item_reg.entry_duration;
    assign tbl_wr_paus = item_reg.entry_pausable;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign stat.act       = item_reg.action;
    assign stat.paused    = paused_reg;
    assign stat.loop_en   = cfg.loop_enable;
    assign stat.sum_done  = (sum_cnt_reg == n) && !live_reg;
    assign stat.mod_need  = !stop_reg && ({1'b0, time_reg} >= (33'(sum_reg) + 33'(DUR_MAX)));
    assign stat.mod_zero  = mod_cnt_reg == '0;
    assign stat.walk_more = walk_more;
    assign stat.fp_more   = fp_more;
    assign stat.out_free  = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

/* rtl/fas_ctrl.sv */
// Controller state machine: decodes the action word and sequences the datapath
// through loop sum, remainder, frame walk and result load. Uses fas_pkg.
`default_nettype none

module fas_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire fas_pkg::dp_stat_t stat,
    output fas_pkg::dp_cmd_t       cmd
);
    import fas_pkg::*;

    localparam logic [2:0] ACT_TICK        = 3'd0;
    localparam logic [2:0] ACT_REQ_PAUSE   = 3'd1;
    localparam logic [2:0] ACT_FORCE_PAUSE = 3'd2;
    localparam logic [2:0] ACT_RESUME      = 3'd3;
    localparam logic [2:0] ACT_FINISH      = 3'd4;
    localparam logic [2:0] ACT_RESET       = 3'd5;
    localparam logic [2:0] ACT_WRITE       = 3'd6;

    typedef enum logic [15:0] {
        S_IDLE    = 16'b0000_0000_0000_0001,
        S_DISP    = 16'b0000_0000_0000_0010,
        S_RS_RD   = 16'b0000_0000_0000_0100,
        S_RS_EV   = 16'b0000_0000_0000_1000,
        S_FN_RD   = 16'b0000_0000_0001_0000,
        S_FN_EV   = 16'b0000_0000_0010_0000,
        S_ADV     = 16'b0000_0000_0100_0000,
        S_SUM     = 16'b0000_0000_1000_0000,
        S_MOD_CHK = 16'b0000_0001_0000_0000,
        S_MOD     = 16'b0000_0010_0000_0000,
        S_W_RD    = 16'b0000_0100_0000_0000,
        S_W_EV    = 16'b0000_1000_0000_0000,
        S_FP_RD   = 16'b0001_0000_0000_0000,
        S_FP_EV   = 16'b0010_0000_0000_0000,
        S_F_RD    = 16'b0100_0000_0000_0000,
        S_F_EV    = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        s_ready    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (stat.act)
                    ACT_TICK: begin
                        cmd.op     = OP_TICK_ADD;
                        state_next = S_ADV;
                    end
                    ACT_REQ_PAUSE: begin
                        cmd.op     = OP_SET_PEND;
                        state_next = S_F_RD;
                    end
                    ACT_FORCE_PAUSE: begin
                        cmd.op     = OP_FP_INIT;
                        state_next = S_FP_RD;
                    end
                    ACT_RESUME: begin
                        cmd.op     = OP_RES_CLR;
                        state_next = S_RS_RD;
                    end
                    ACT_FINISH: begin
                        if (stat.loop_en) begin
                            cmd.op     = OP_FAIL;
                            state_next = S_F_RD;
                        end else begin
                            cmd.op     = OP_FIN_SET;
                            state_next = S_FN_RD;
                        end
                    end
                    ACT_RESET: begin
                        cmd.op     = OP_RST_POS;
                        state_next = S_F_RD;
                    end
                    ACT_WRITE: begin
                        cmd.op     = OP_TBL_WR;
                        state_next = S_F_RD;
                    end
                    default: begin
                        state_next = S_F_RD;
                    end
                endcase
            end
            S_RS_RD: begin
                state_next = S_RS_EV;
            end
            S_RS_EV: begin
                cmd.op     = OP_RES_CLAMP;
                state_next = S_ADV;
            end
            S_FN_RD: begin
                state_next = S_FN_EV;
            end
            S_FN_EV: begin
                cmd.op     = OP_FIN_TIME;
                state_next = S_ADV;
            end
            S_ADV: begin
                if (stat.paused) begin
                    state_next = S_F_RD;
                end else if (stat.loop_en) begin
                    cmd.op     = OP_SUM_INIT;
                    state_next = S_SUM;
                end else begin
                    state_next = S_W_RD;
                end
            end
            S_SUM: begin
                cmd.op = OP_SUM_STEP;
                if (stat.sum_done) begin
                    state_next = S_MOD_CHK;
                end
            end
            S_MOD_CHK: begin
                if (stat.mod_need) begin
                    cmd.op     = OP_MOD_INIT;
                    state_next = S_MOD;
                end else begin
                    state_next = S_W_RD;
                end
            end
            S_MOD: begin
                if (stat.mod_zero) begin
                    cmd.op     = OP_MOD_FIN;
                    state_next = S_W_RD;
                end else begin
                    cmd.op = OP_MOD_STEP;
                end
            end
            S_W_RD: begin
                state_next = S_W_EV;
            end
            S_W_EV: begin
                cmd.op     = OP_WALK;
                state_next = stat.walk_more ? S_W_RD : S_F_RD;
            end
            S_FP_RD: begin
                state_next = S_FP_EV;
            end
            S_FP_EV: begin
                cmd.op     = OP_FP_EVAL;
                state_next = stat.fp_more ? S_FP_RD : S_F_RD;
            end
            S_F_RD: begin
                state_next = S_F_EV;
            end
            S_F_EV: begin
                // hold here while the previous result is still unclaimed
                if (stat.out_free) begin
                    cmd.op     = OP_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
